// ----- src/soiir_pkg.sv -----
// Shared types, constants and helpers for the biquad IIR section.
package soiir_pkg;

  localparam int COEFF_W    = 18;
  localparam int DELAY_W    = 40;
  localparam int NUM_COEFFS = 5;
  localparam int CIDX_W     = 3;
  localparam int MUL_B_W    = 33;
  localparam int PROD_W     = COEFF_W + MUL_B_W;
  localparam int SPLIT      = DELAY_W / 2;
  localparam int SUM_W      = 61;

  typedef logic [CIDX_W-1:0] coeff_idx_t;

  localparam coeff_idx_t CIDX_FEED_NOW = 3'd0;
  localparam coeff_idx_t CIDX_FEED_ONE = 3'd1;
  localparam coeff_idx_t CIDX_BACK_ONE = 3'd2;
  localparam coeff_idx_t CIDX_FEED_TWO = 3'd3;
  localparam coeff_idx_t CIDX_BACK_TWO = 3'd4;

  localparam logic signed [SUM_W-1:0] DELAY_MAX =
      SUM_W'((64'sd1 <<< (DELAY_W - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] DELAY_MIN =
      SUM_W'(-(64'sd1 <<< (DELAY_W - 1)));

  typedef enum logic [1:0] {
    SRC_X,
    SRC_YLO,
    SRC_YHI
  } mul_src_e;

  typedef struct packed {
    logic       load_x;
    mul_src_e   mul_src;
    coeff_idx_t mul_coef;
    logic       do_yw;
    logic       do_t0;
    logic       do_t1;
    logic       do_lo;
    logic       do_hi;
    logic       do_nd0;
    logic       do_nd1;
    logic       do_out;
  } dp_cmd_t;

  typedef struct packed {
    logic out_full;
  } dp_status_t;

  function automatic logic signed [DELAY_W-1:0] sat_delay(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    if (v > DELAY_MAX) begin
      r = DELAY_MAX;
    end else if (v < DELAY_MIN) begin
      r = DELAY_MIN;
    end else begin
      r = v;
    end
    return r[DELAY_W-1:0];
  endfunction

endpackage

// ----- src/soiir_ctrl.sv -----
// Step sequencer for the shared-multiplier biquad datapath.
module soiir_ctrl import soiir_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_C0   = 4'd1;
  localparam logic [3:0] S_C1   = 4'd2;
  localparam logic [3:0] S_C2   = 4'd3;
  localparam logic [3:0] S_C3   = 4'd4;
  localparam logic [3:0] S_C4   = 4'd5;
  localparam logic [3:0] S_C5   = 4'd6;
  localparam logic [3:0] S_C6   = 4'd7;
  localparam logic [3:0] S_C7   = 4'd8;
  localparam logic [3:0] S_C8   = 4'd9;

  logic [3:0] step_q, step_d;

  assign in_stall_o = (step_q != S_IDLE);

  always_comb begin
    cmd_o          = '0;
    cmd_o.mul_src  = SRC_X;
    cmd_o.mul_coef = CIDX_FEED_NOW;
    step_d         = step_q;
    case (step_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_x = 1'b1;
          step_d       = S_C0;
        end
      end
      S_C0: begin
        cmd_o.mul_coef = CIDX_FEED_NOW;
        step_d         = S_C1;
      end
      S_C1: begin
        cmd_o.mul_coef = CIDX_FEED_ONE;
        cmd_o.do_yw    = 1'b1;
        step_d         = S_C2;
      end
      S_C2: begin
        cmd_o.mul_coef = CIDX_FEED_TWO;
        cmd_o.do_t0    = 1'b1;
        step_d         = S_C3;
      end
      S_C3: begin
        cmd_o.mul_coef = CIDX_BACK_ONE;
        cmd_o.mul_src  = SRC_YLO;
        cmd_o.do_t1    = 1'b1;
        step_d         = S_C4;
      end
      S_C4: begin
        cmd_o.mul_coef = CIDX_BACK_ONE;
        cmd_o.mul_src  = SRC_YHI;
        cmd_o.do_lo    = 1'b1;
        step_d         = S_C5;
      end
      S_C5: begin
        cmd_o.mul_coef = CIDX_BACK_TWO;
        cmd_o.mul_src  = SRC_YLO;
        cmd_o.do_hi    = 1'b1;
        step_d         = S_C6;
      end
      S_C6: begin
        cmd_o.mul_coef = CIDX_BACK_TWO;
        cmd_o.mul_src  = SRC_YHI;
        cmd_o.do_nd0   = 1'b1;
        cmd_o.do_lo    = 1'b1;
        step_d         = S_C7;
      end
      S_C7: begin
        cmd_o.do_hi = 1'b1;
        step_d      = S_C8;
      end
      S_C8: begin
        if (!(status_i.out_full && out_stall_i)) begin
          cmd_o.do_nd1 = 1'b1;
          cmd_o.do_out = 1'b1;
          step_d       = S_IDLE;
        end
      end
      default: begin
        step_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// ----- src/soiir_datapath.sv -----
// Coefficient registers, shared multiplier, delay accumulators and output stage.
module soiir_datapath import soiir_pkg::*; #(
  parameter int DATA_WIDTH      = 16,
  parameter int COEFF_FRAC_BITS = 14
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  coeff_idx_t                   cfg_index_i,
  input  logic signed [COEFF_W-1:0]    cfg_data_i,
  input  logic signed [DATA_WIDTH-1:0] sample_i,
  input  dp_cmd_t                      cmd_i,
  input  logic                         out_stall_i,
  output dp_status_t                   status_o,
  output logic                         out_valid_o,
  output logic signed [DATA_WIDTH-1:0] filtered_o,
  output logic                         clipped_o
);

  localparam logic signed [SUM_W-1:0] HALF =
      SUM_W'(64'sd1 <<< (COEFF_FRAC_BITS - 1));
  localparam logic signed [COEFF_W-1:0] UNITY =
      COEFF_W'(64'sd1 <<< COEFF_FRAC_BITS);
  localparam logic signed [SUM_W-1:0] OUT_MAX =
      SUM_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] OUT_MIN =
      SUM_W'(-(64'sd1 <<< (DATA_WIDTH - 1)));

  logic signed [COEFF_W-1:0]    coeff_q [NUM_COEFFS];
  logic signed [DATA_WIDTH-1:0] x_q;
  logic signed [MUL_B_W-1:0]    mul_b;
  logic signed [PROD_W-1:0]     prod, p_q;
  logic signed [DELAY_W-1:0]    d0_q, d1_q, yw_q;
  logic signed [SUM_W-1:0]      t_q, u_q, s_q, s_scaled, yr;
  logic signed [DATA_WIDTH-1:0] filt_d, filt_q;
  logic                         clip_d, clip_q;
  logic                         out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COEFFS; i++) begin
        coeff_q[i] <= (i == 0) ? UNITY : '0;
      end
    end else if (cfg_we_i && (cfg_index_i < CIDX_W'(NUM_COEFFS))) begin
      coeff_q[cfg_index_i] <= cfg_data_i;
    end
  end

  always_comb begin
    case (cmd_i.mul_src)
      SRC_X:   mul_b = MUL_B_W'(x_q);
      SRC_YLO: mul_b = $signed({{(MUL_B_W - SPLIT){1'b0}}, yw_q[SPLIT-1:0]});
      SRC_YHI: mul_b = MUL_B_W'($signed(yw_q[DELAY_W-1:SPLIT]));
      default: mul_b = MUL_B_W'(x_q);
    endcase
  end

  assign prod     = PROD_W'(coeff_q[cmd_i.mul_coef]) * PROD_W'(mul_b);
  assign s_scaled = s_q >>> COEFF_FRAC_BITS;

  // payload registers
  always_ff @(posedge clk_i) begin
    p_q <= prod;
    if (cmd_i.load_x) x_q <= sample_i;
    if (cmd_i.do_yw)  yw_q <= sat_delay(SUM_W'(d0_q) + SUM_W'(p_q));
    if (cmd_i.do_t0)  t_q <= SUM_W'(d1_q) + SUM_W'(p_q);
    if (cmd_i.do_t1)  u_q <= SUM_W'(p_q);
    if (cmd_i.do_lo) begin
      s_q <= SUM_W'(p_q) + HALF;
    end else if (cmd_i.do_hi) begin
      s_q <= s_q + (SUM_W'(p_q) <<< SPLIT);
    end
    if (cmd_i.do_out) begin
      filt_q <= filt_d;
      clip_q <= clip_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d0_q <= '0;
      d1_q <= '0;
    end else begin
      if (cmd_i.do_nd0) d0_q <= sat_delay(t_q + s_scaled);
      if (cmd_i.do_nd1) d1_q <= sat_delay(u_q + s_scaled);
    end
  end

  // round half up, then saturate to the output word
  always_comb begin
    yr = (SUM_W'(yw_q) + HALF) >>> COEFF_FRAC_BITS;
    if (yr > OUT_MAX) begin
      filt_d = OUT_MAX[DATA_WIDTH-1:0];
      clip_d = 1'b1;
    end else if (yr < OUT_MIN) begin
      filt_d = OUT_MIN[DATA_WIDTH-1:0];
      clip_d = 1'b1;
    end else begin
      filt_d = yr[DATA_WIDTH-1:0];
      clip_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.do_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign status_o.out_full = out_valid_q;
  assign out_valid_o       = out_valid_q;
  assign filtered_o        = filt_q;
  assign clipped_o         = clip_q;

endmodule

// ----- src/second_order_iir_biquad.sv -----
// Top level of the second-order IIR section, transposed direct form II.
// One signed sample word in, one rounded and saturated sample word out, with clipped set
// when saturation changed the value. Five signed Q3.14 coefficients are written through
// cfg_we_i/cfg_index_i/cfg_data_i (index 0..4: feed_now, feed_one, back_one, feed_two,
// back_two; other indexes are ignored). A new sample is not accepted until the previous
// one is through every step: one 18x33 multiplier is shared by all seven partial
// products (three feedforward, two split feedback products of the 40-bit output), one
// per cycle. The last step waits while an earlier result is still held on the output.
module second_order_iir_biquad import soiir_pkg::*; #(
  parameter int DATA_WIDTH      = 16,
  parameter int COEFF_FRAC_BITS = 14
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CIDX_W-1:0]            cfg_index_i,
  input  logic signed [COEFF_W-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [DATA_WIDTH-1:0] sample_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [DATA_WIDTH-1:0] filtered_o,
  output logic                         clipped_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  soiir_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  soiir_datapath #(
    .DATA_WIDTH      (DATA_WIDTH),
    .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .sample_i    (sample_i),
    .cmd_i       (cmd),
    .out_stall_i (out_stall_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .filtered_o  (filtered_o),
    .clipped_o   (clipped_o)
  );

endmodule

// ----- bench/second_order_iir_biquad_tb.sv -----
// Self-checking bench for the biquad IIR section: queued sample words, predicted outputs.
module second_order_iir_biquad_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import soiir_pkg::*;

  localparam int DW            = 16;
  localparam int FRAC          = 14;
  localparam int SETTLE        = 20;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_WORDS   = 110;
  localparam int LAST_WORDS    = 100;

  localparam logic signed [COEFF_W-1:0] C_MIN = {1'b1, {(COEFF_W-1){1'b0}}};
  localparam logic signed [COEFF_W-1:0] C_MAX = {1'b0, {(COEFF_W-1){1'b1}}};
  localparam logic signed [COEFF_W-1:0] C_ONE = COEFF_W'(1 << FRAC);
  localparam logic signed [DW-1:0]      S_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0]      S_MAX = {1'b0, {(DW-1){1'b1}}};

  typedef struct {
    logic signed [DW-1:0] filtered;
    logic                 clipped;
  } biquad_out_t;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        cfg_we_i    = 1'b0;
  coeff_idx_t                  cfg_index_i = CIDX_FEED_NOW;
  logic signed [COEFF_W-1:0]   cfg_data_i  = '0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_stall_o;
  logic signed [DW-1:0]        sample_i    = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic signed [DW-1:0]        filtered_o;
  logic                        clipped_o;

  logic signed [DW-1:0] send_queue[$];
  biquad_out_t          filtered_due[$];

  longint gain[NUM_COEFFS];
  longint delay_one;
  longint delay_two;

  int   error_count = 0;
  int   cycle_count = 0;
  int   send_gap;
  int   recv_gap;
  int   gap_odds    = 0;
  int   stall_odds  = 0;
  int   hold_cnt;
  logic hold_ask    = 1'b0;
  logic hold_done;

  second_order_iir_biquad #(
    .DATA_WIDTH     (DW),
    .COEFF_FRAC_BITS(FRAC)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sample_i   (sample_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .filtered_o (filtered_o),
    .clipped_o  (clipped_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint clamp_to(input longint v, input int w, output logic hit);
    longint hi;
    longint lo;
    hi  = (longint'(1) <<< (w - 1)) - 1;
    lo  = -hi - 1;
    hit = 1'b0;
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // feedback product brought back to delay scale, round half up
  function automatic longint round_fb(input longint c, input longint y);
    return (c * y + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic biquad_out_t biquad_step(input logic signed [DW-1:0] x);
    longint      xs;
    longint      yw;
    longint      nd0;
    longint      nd1;
    longint      yr;
    logic        hit;
    biquad_out_t r;
    xs  = x;
    yw  = clamp_to(delay_one + gain[CIDX_FEED_NOW] * xs, DELAY_W, hit);
    nd0 = delay_two + gain[CIDX_FEED_ONE] * xs + round_fb(gain[CIDX_BACK_ONE], yw);
    nd1 = gain[CIDX_FEED_TWO] * xs + round_fb(gain[CIDX_BACK_TWO], yw);
    delay_one  = clamp_to(nd0, DELAY_W, hit);
    delay_two  = clamp_to(nd1, DELAY_W, hit);
    yr         = (yw + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    r.filtered = DW'(clamp_to(yr, DW, hit));
    r.clipped  = hit;
    return r;
  endfunction

  function automatic logic signed [DW-1:0] pick_sample(input logic signed [DW-1:0] prev);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return DW'($urandom());
      4, 5, 6:    return DW'(int'($urandom_range(0, 4096)) - 2048);
      7: begin
        case ($urandom_range(0, 3))
          0:       return S_MIN;
          1:       return S_MAX;
          2:       return '0;
          default: return '1;
        endcase
      end
      default:    return prev;
    endcase
  endfunction

  function automatic int pick_odds();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 3;
      2:       return 6;
      default: return 12;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic write_coeff(input coeff_idx_t idx, input logic signed [COEFF_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx < NUM_COEFFS) begin
      gain[idx] = value;
    end
  endtask

  task automatic write_all(input logic signed [COEFF_W-1:0] value);
    for (int i = 0; i < NUM_COEFFS; i++) begin
      write_coeff(coeff_idx_t'(i), value);
    end
  endtask

  task automatic random_coeffs();
    int                        a1;
    int                        a2;
    int                        lim;
    int                        pick;
    logic signed [COEFF_W-1:0] c[NUM_COEFFS];
    pick = $urandom_range(0, 3);
    if ($urandom_range(0, 1) == 1) begin
      write_coeff(coeff_idx_t'($urandom_range(NUM_COEFFS, (1 << CIDX_W) - 1)),
                  COEFF_W'($urandom()));
    end
    case (pick)
      0: begin
        for (int i = 0; i < NUM_COEFFS; i++) c[i] = COEFF_W'($urandom());
      end
      2: begin
        for (int i = 0; i < NUM_COEFFS; i++) begin
          case ($urandom_range(0, 4))
            0:       c[i] = C_MIN;
            1:       c[i] = C_MAX;
            2:       c[i] = '0;
            3:       c[i] = C_ONE;
            default: c[i] = -C_ONE;
          endcase
        end
      end
      default: begin
        // poles kept inside the stability triangle
        a2  = int'($urandom_range(0, 29000)) - 14500;
        lim = ((1 << FRAC) + a2) * 9 / 10;
        a1  = int'($urandom_range(0, 2 * lim)) - lim;
        c[CIDX_BACK_ONE] = COEFF_W'(-a1);
        c[CIDX_BACK_TWO] = COEFF_W'(-a2);
        c[CIDX_FEED_NOW] = COEFF_W'(int'($urandom_range(0, 16384)) - 8192);
        c[CIDX_FEED_ONE] = COEFF_W'(int'($urandom_range(0, 16384)) - 8192);
        c[CIDX_FEED_TWO] = COEFF_W'(int'($urandom_range(0, 16384)) - 8192);
        if (pick == 3) begin
          c[CIDX_FEED_NOW] = COEFF_W'(int'($urandom_range(0, 262142)) - 131071);
        end
      end
    endcase
    for (int i = 0; i < NUM_COEFFS; i++) begin
      write_coeff(coeff_idx_t'(i), c[i]);
    end
  endtask

  task automatic load_words(input int count);
    logic signed [DW-1:0] s;
    s = '0;
    @(negedge clk_i);
    repeat (count) begin
      s = pick_sample(s);
      send_queue.push_back(s);
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk_i); while (send_queue.size() != 0 || in_valid_i || filtered_due.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // sender
  always @(posedge clk_i) begin
    logic fire;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap   <= 0;
    end else begin
      fire = in_valid_i && !in_stall_o;
      if (fire) begin
        filtered_due.push_back(biquad_step(sample_i));
      end
      if (in_valid_i && !fire) begin
        // hold the stalled word
      end else if (send_gap != 0) begin
        send_gap   <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (send_queue.size() != 0) begin
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
          send_gap   <= $urandom_range(0, 9);
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i <= 1'b1;
          sample_i   <= send_queue.pop_front();
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (hold_ask && !hold_done) begin
      hold_cnt  <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // receiver and checker
  always @(posedge clk_i) begin
    biquad_out_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_gap    <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (filtered_due.size() == 0) begin
          report_mismatch($sformatf("word %0d/%0b with none expected", filtered_o, clipped_o));
        end else begin
          want = filtered_due.pop_front();
          if (filtered_o !== want.filtered) begin
            report_mismatch($sformatf("filtered %0d, want %0d", filtered_o, want.filtered));
          end
          if (clipped_o !== want.clipped) begin
            report_mismatch($sformatf("clipped %0b, want %0b", clipped_o, want.clipped));
          end
        end
      end
      if (hold_cnt != 0) begin
        out_stall_i <= 1'b1;
      end else if (recv_gap != 0) begin
        recv_gap    <= recv_gap - 1;
        out_stall_i <= 1'b1;
      end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        recv_gap    <= $urandom_range(0, 9);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    gain[CIDX_FEED_NOW] = longint'(1) <<< FRAC;
    gain[CIDX_FEED_ONE] = 0;
    gain[CIDX_BACK_ONE] = 0;
    gain[CIDX_FEED_TWO] = 0;
    gain[CIDX_BACK_TWO] = 0;
    delay_one = 0;
    delay_two = 0;
    repeat (3) @(posedge clk_i);
    rst_ni     <= 1'b1;
    gap_odds   <= 6;
    stall_odds <= 6;

    // reset gains: unity pass-through at the sample extremes
    @(negedge clk_i);
    send_queue = '{S_MIN, S_MAX, 0, -1, 1};
    wait_idle();

    // smallest gain: round half up in both signs; unused indexes must not land
    write_coeff(CIDX_FEED_NOW, COEFF_W'(1));
    for (int i = NUM_COEFFS; i < (1 << CIDX_W); i++) begin
      write_coeff(coeff_idx_t'(i), C_MIN);
    end
    @(negedge clk_i);
    send_queue = '{8192, -8192, 24576, -24576, 8191};
    wait_idle();

    // full-scale gains: output clipping and delay saturation
    write_all(C_MAX);
    @(negedge clk_i);
    send_queue = '{S_MAX, S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MAX, 0};
    wait_idle();

    write_all(C_MIN);
    @(negedge clk_i);
    send_queue = '{S_MIN, S_MAX, S_MIN, S_MAX, 0, 0, 0};
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_coeffs();
      gap_odds   <= pick_odds();
      stall_odds <= pick_odds();
      load_words(PHASE_WORDS);
      if (p == 2) begin
        hold_ask <= 1'b1;
      end
      wait_idle();
    end

    random_coeffs();
    gap_odds   <= 0;
    stall_odds <= 0;
    load_words(LAST_WORDS);
    wait_idle();

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/soiir_pkg.sv
src/soiir_ctrl.sv
src/soiir_datapath.sv
src/second_order_iir_biquad.sv
bench/second_order_iir_biquad_tb.sv
